// ===== rtl/core/imutv_pkg.sv =====
// Package for the track velocity estimator: item types, register indexes,
// serial unit request types and saturation helpers. No dependencies.
package imutv_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [2:0] REG_SIDE_RIGHT  = 3'd0;
    localparam logic [2:0] REG_HALF_TRACK  = 3'd1;
    localparam logic [2:0] REG_GRAVITY     = 3'd2;
    localparam logic [2:0] REG_DEAD_ZONE   = 3'd3;
    localparam logic [2:0] REG_STILL       = 3'd4;
    localparam logic [2:0] REG_BLEND       = 3'd5;
    localparam logic [2:0] REG_CALIB       = 3'd6;

    localparam logic OP_IMU  = 1'b0;
    localparam logic OP_ODOM = 1'b1;

    typedef struct packed {
        logic               op;
        logic [31:0]        stamp_us;
        logic signed [31:0] accel_x;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] imu_yaw_rate;
        logic signed [31:0] odom_speed;
        logic signed [31:0] odom_turn_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] track_velocity;
        logic signed [31:0] yaw_rate_out;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage

// ===== rtl/core/imu_track_velocity_estimator.sv =====
// Top level of the track velocity estimator: APB registers, sequencer and
// the shared serial multiplier and divider. Depends on imutv_pkg, imutv_mul, imutv_div.
//
// channel   signals                          accepted when
// in        in_valid in_ready in_data        in_valid && in_ready
// out       out_valid out_ready out_data     out_valid && out_ready
// cfg       psel penable pwrite paddr pwdata psel && penable && pwrite
//
// A product: start, 32 shift-add steps, done; a quotient: start, restoring steps, done.
// Odometry item: accept plus one product. First IMU item: accept only.
// Calibration item: three products, plus the bias division on the last one.
// Running IMU item: six products, one quotient, accept, clean and result steps,
// all through the single multiplier and divider.
// One item at a time; a result waits in the output register, and a finished
// item stalls only if the previous result has not been taken. Async reset.
module imu_track_velocity_estimator
    import imutv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_Q1     = 4'd1;
    localparam logic [3:0] S_Q2     = 4'd2;
    localparam logic [3:0] S_GRAV   = 4'd3;
    localparam logic [3:0] S_CALDIV = 4'd4;
    localparam logic [3:0] S_CLEAN  = 4'd5;
    localparam logic [3:0] S_INC    = 4'd6;
    localparam logic [3:0] S_INCDIV = 4'd7;
    localparam logic [3:0] S_BL1    = 4'd8;
    localparam logic [3:0] S_BL2    = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_ODOM   = 4'd11;

    localparam logic [16:0] BW_ONE   = 17'd65536;
    localparam logic [31:0] US_PER_S = 32'd1000000;
    localparam logic signed [67:0] S_MAX = 68'sd268435456;

    logic        side_reg;
    logic [30:0] half_reg;
    logic [30:0] grav_reg;
    logic [30:0] dz_reg;
    logic [30:0] still_reg;
    logic [16:0] bw_reg;
    logic [7:0]  calib_reg;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic        pend_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;
    in_item_t    item_reg;

    logic signed [31:0] vel_reg;
    logic signed [31:0] ref_reg;
    logic [31:0]        last_reg;
    logic               first_reg;
    logic               cal_reg;
    logic [7:0]         cnt_reg;
    logic signed [47:0] bsum_reg;
    logic signed [31:0] bias_reg;
    logic [31:0]        dt_reg;
    logic signed [65:0] p_reg;
    logic signed [29:0] s_reg;
    logic signed [31:0] ax_reg;
    logic signed [31:0] clean_reg;
    logic [63:0]        t_reg;

    mul_req_t           mreq;
    div_req_t           dreq;
    logic               mul_done;
    logic signed [65:0] mul_prod;
    logic               div_done;
    logic [63:0]        div_q;

    logic               cfg_wr;
    logic [16:0]        bw_eff;
    logic [7:0]         n_eff;
    logic               is_mul_state;
    logic               is_div_state;
    logic signed [67:0] s_diff;
    logic signed [29:0] s_sat;
    logic signed [65:0] g_term;
    logic signed [31:0] ax_new;
    logic signed [47:0] bsum_new;
    logic [7:0]         cnt_new;
    logic signed [31:0] clean_sat;
    logic signed [31:0] clean_dz;
    logic signed [67:0] vel_inc;
    logic signed [66:0] blend_sum;
    logic signed [65:0] odom_term;
    logic signed [31:0] odom_ref;
    logic               still;
    logic [47:0]        bsum_mag;

    imutv_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    imutv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (div_done),
        .quot  (div_q)
    );

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign bw_eff = (bw_reg > BW_ONE) ? BW_ONE : bw_reg;
    assign n_eff  = (calib_reg == 8'd0) ? 8'd1 : calib_reg;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SIDE_RIGHT: prdata = {31'd0, side_reg};
            REG_HALF_TRACK: prdata = {1'b0, half_reg};
            REG_GRAVITY:    prdata = {1'b0, grav_reg};
            REG_DEAD_ZONE:  prdata = {1'b0, dz_reg};
            REG_STILL:      prdata = {1'b0, still_reg};
            REG_BLEND:      prdata = {15'd0, bw_reg};
            REG_CALIB:      prdata = {24'd0, calib_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= 1'b0;
            half_reg  <= 31'd16384;
            grav_reg  <= 31'd642908;
            dz_reg    <= 31'd5243;
            still_reg <= 31'd655;
            bw_reg    <= 17'd1311;
            calib_reg <= 8'd150;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_SIDE_RIGHT: side_reg  <= pwdata[0];
                REG_HALF_TRACK: half_reg  <= pwdata[30:0];
                REG_GRAVITY:    grav_reg  <= pwdata[30:0];
                REG_DEAD_ZONE:  dz_reg    <= pwdata[30:0];
                REG_STILL:      still_reg <= pwdata[30:0];
                REG_BLEND:      bw_reg    <= pwdata[16:0];
                REG_CALIB:      calib_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // operand selection for the shared units
    always_comb
    begin
        mreq.a   = 32'd0;
        mreq.b   = 32'd0;
        mreq.neg = 1'b0;
        is_mul_state = 1'b1;
        unique case (state_reg)
            S_Q1:
            begin
                mreq.a   = abs32(32'(item_reg.quat_w));
                mreq.b   = abs32(32'(item_reg.quat_y));
                mreq.neg = item_reg.quat_w[15] ^ item_reg.quat_y[15];
            end
            S_Q2:
            begin
                mreq.a   = abs32(32'(item_reg.quat_x));
                mreq.b   = abs32(32'(item_reg.quat_z));
                mreq.neg = item_reg.quat_x[15] ^ item_reg.quat_z[15];
            end
            S_GRAV:
            begin
                mreq.a   = {1'b0, grav_reg};
                mreq.b   = abs32(32'(s_reg));
                mreq.neg = s_reg[29];
            end
            S_INC:
            begin
                mreq.a = abs32(clean_reg);
                mreq.b = dt_reg;
            end
            S_BL1:
            begin
                mreq.a   = abs32(vel_reg);
                mreq.b   = {15'd0, BW_ONE - bw_eff};
                mreq.neg = vel_reg[31];
            end
            S_BL2:
            begin
                mreq.a   = abs32(ref_reg);
                mreq.b   = {15'd0, bw_eff};
                mreq.neg = ref_reg[31];
            end
            S_ODOM:
            begin
                mreq.a   = abs32(item_reg.odom_turn_rate);
                mreq.b   = {1'b0, half_reg};
                mreq.neg = item_reg.odom_turn_rate[31];
            end
            default: is_mul_state = 1'b0;
        endcase
        mreq.start = is_mul_state && !pend_reg;
    end

    assign bsum_mag = bsum_reg[47] ? 48'(-bsum_reg) : 48'(bsum_reg);

    always_comb
    begin
        dreq.num = 64'd0;
        dreq.den = 32'd0;
        is_div_state = 1'b1;
        unique case (state_reg)
            S_CALDIV:
            begin
                dreq.num = {16'd0, bsum_mag};
                dreq.den = {24'd0, n_eff};
            end
            S_INCDIV:
            begin
                dreq.num = t_reg;
                dreq.den = US_PER_S;
            end
            default: is_div_state = 1'b0;
        endcase
        dreq.start = is_div_state && !pend_reg;
    end

    // datapath arithmetic on unit results
    always_comb
    begin
        s_diff = (68'(p_reg) - 68'(mul_prod)) <<< 1;
        if (s_diff > S_MAX)
            s_sat = 30'(S_MAX);
        else if (s_diff < -S_MAX)
            s_sat = 30'(-S_MAX);
        else
            s_sat = s_diff[29:0];

        g_term   = mul_prod >>> 28;
        ax_new   = sat32(68'(item_reg.accel_x) - 68'(g_term));
        bsum_new = bsum_reg + 48'(ax_new);
        cnt_new  = cnt_reg + 8'd1;

        clean_sat = sat32(68'(ax_reg) - 68'(bias_reg));
        clean_dz  = ({1'b0, abs32(clean_sat)} < {2'b00, dz_reg}) ? 32'sd0 : clean_sat;

        vel_inc = clean_reg[31] ? 68'(vel_reg) - $signed({4'd0, div_q})
                                : 68'(vel_reg) + $signed({4'd0, div_q});

        blend_sum = 67'(p_reg) + 67'(mul_prod);

        odom_term = mul_prod >>> FRAC_BITS;
        odom_ref  = side_reg ? sat32(68'(item_reg.odom_speed) + 68'(odom_term))
                             : sat32(68'(item_reg.odom_speed) - 68'(odom_term));
        still = ({1'b0, abs32(item_reg.odom_speed)} < {2'b00, still_reg})
             && ({1'b0, abs32(item_reg.odom_turn_rate)} < {2'b00, still_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.op == OP_ODOM)
                        state_next = S_ODOM;
                    else if (!first_reg)
                        state_next = S_Q1;
                end
            end
            S_Q1:     if (mul_done) state_next = S_Q2;
            S_Q2:     if (mul_done) state_next = S_GRAV;
            S_GRAV:
            begin
                if (mul_done)
                begin
                    if (cal_reg)
                        state_next = S_CLEAN;
                    else if (cnt_new >= n_eff)
                        state_next = S_CALDIV;
                    else
                        state_next = S_IDLE;
                end
            end
            S_CALDIV: if (div_done) state_next = S_IDLE;
            S_CLEAN:  state_next = S_INC;
            S_INC:    if (mul_done) state_next = S_INCDIV;
            S_INCDIV: if (div_done) state_next = S_BL1;
            S_BL1:    if (mul_done) state_next = S_BL2;
            S_BL2:    if (mul_done) state_next = S_FIN;
            S_FIN:    if (!out_valid_reg || out_ready) state_next = S_IDLE;
            S_ODOM:   if (mul_done) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            vel_reg       <= 32'sd0;
            ref_reg       <= 32'sd0;
            last_reg      <= 32'd0;
            first_reg     <= 1'b1;
            cal_reg       <= 1'b0;
            cnt_reg       <= 8'd0;
            bsum_reg      <= 48'sd0;
            bias_reg      <= 32'sd0;
        end
        else
        begin
            state_reg <= state_next;
            if (mreq.start || dreq.start)
                pend_reg <= 1'b1;
            else if (mul_done || div_done)
                pend_reg <= 1'b0;

            // a new result replaces the one taken in the same cycle
            if (state_reg == S_FIN && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_data.op == OP_IMU)
                    begin
                        last_reg  <= in_data.stamp_us;
                        first_reg <= 1'b0;
                    end
                end
                S_GRAV:
                begin
                    if (mul_done && !cal_reg)
                    begin
                        bsum_reg <= bsum_new;
                        cnt_reg  <= cnt_new;
                    end
                end
                S_CALDIV:
                begin
                    if (div_done)
                    begin
                        bias_reg <= bsum_reg[47] ? -$signed(div_q[31:0])
                                                 : $signed(div_q[31:0]);
                        cal_reg  <= 1'b1;
                    end
                end
                S_INCDIV: if (div_done) vel_reg <= sat32(vel_inc);
                S_BL2:    if (mul_done) vel_reg <= sat32(68'(blend_sum >>> 16));
                S_ODOM:
                begin
                    if (mul_done)
                    begin
                        // still robot: drop the velocity before the new reference
                        if (still)
                            vel_reg <= 32'sd0;
                        ref_reg <= odom_ref;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_data;
            dt_reg   <= in_data.stamp_us - last_reg;
        end
        if ((state_reg == S_Q1 || state_reg == S_BL1) && mul_done)
            p_reg <= mul_prod;
        if (state_reg == S_Q2 && mul_done)
            s_reg <= s_sat;
        if (state_reg == S_GRAV && mul_done)
            ax_reg <= ax_new;
        if (state_reg == S_CLEAN)
            clean_reg <= clean_dz;
        if (state_reg == S_INC && mul_done)
            t_reg <= mul_prod[63:0];
        if (state_reg == S_FIN && (!out_valid_reg || out_ready))
        begin
            out_reg.track_velocity <= vel_reg;
            out_reg.yaw_rate_out   <= item_reg.imu_yaw_rate;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_reg)
        else $error("unit request pending while idle");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mreq.start && dreq.start))
        else $error("multiplier and divider started together");

    a_out_calibrated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cal_reg && !first_reg)
        else $error("result before calibration ended");

    a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> is_mul_state && pend_reg)
        else $error("product finished outside a multiply step");
`endif

endmodule

// ===== rtl/core/imutv_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, through all 32 bits of the multiplier.
// Depends on imutv_pkg for the request type.
module imutv_mul
    import imutv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mul_req_t           req,
    output logic               done,
    output logic signed [65:0] prod
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] a_reg;
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    logic        neg_reg;
    logic [32:0] sum;
    logic signed [65:0] mag;

    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : 33'd0);
    assign mag  = $signed({2'b00, hi_reg, lo_reg});
    assign prod = neg_reg ? -mag : mag;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            hi_reg  <= 32'd0;
            lo_reg  <= req.b;
            neg_reg <= req.neg;
        end
        else if (busy_reg)
        begin
            // shift the partial sum down, next multiplier bit moves to lo[0]
            hi_reg <= sum[32:1];
            lo_reg <= {sum[0], lo_reg[31:1]};
        end
    end

endmodule

// ===== rtl/core/imutv_div.sv =====
// Restoring divider, one quotient bit per cycle, through all 64 bits of the dividend.
// Depends on imutv_pkg for the request type.
module imutv_div
    import imutv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        done,
    output logic [63:0] quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [63:0] q_reg;
    logic [33:0] diff;
    logic        fit;

    assign diff = {1'b0, rem_reg, q_reg[63]} - {2'b00, den_reg};
    assign fit  = !diff[33];
    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.den;
            rem_reg <= 32'd0;
            q_reg   <= req.num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fit ? diff[31:0] : {rem_reg[30:0], q_reg[63]};
            q_reg   <= {q_reg[62:0], fit};
        end
    end

endmodule

// ===== tb/tb_imutv_checker.sv =====
// Checker for the track velocity estimator: watches the item channels and
// register writes, predicts each result and compares. Depends on imutv_pkg.
module tb_imutv_checker
    import imutv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        side_right;
    logic [30:0] half_track, gravity, dead_zone, still_thr;
    logic [16:0] blend_w;
    logic [7:0]  calib_n;

    logic signed [31:0] vel, ref_speed, bias;
    logic [31:0]        last_stamp;
    logic               first_pending, calibrated;
    logic [7:0]         n_seen;
    logic signed [63:0] bias_acc;

    out_item_t velocity_q[$];

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -128'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic track_item(input in_item_t it);
        logic signed [127:0] v, w, t, s, g, ax, clean, prod;
        logic [127:0]        mag;
        logic [31:0]         dt;
        logic [16:0]         bw;
        logic [7:0]          n;
        out_item_t           r;
        if (it.op == OP_ODOM) begin
            v = it.odom_speed;
            w = it.odom_turn_rate;
            if ((v < 0 ? -v : v) < still_thr && (w < 0 ? -w : w) < still_thr)
                vel = 0;
            t = (w * $signed({97'd0, half_track})) >>> FRAC_BITS;
            ref_speed = clamp32(side_right ? v + t : v - t);
            return;
        end
        if (first_pending) begin
            last_stamp = it.stamp_us;
            first_pending = 0;
            return;
        end
        dt = it.stamp_us - last_stamp;
        last_stamp = it.stamp_us;
        s = 2 * (128'(it.quat_w) * it.quat_y - 128'(it.quat_x) * it.quat_z);
        if (s > (128'sd1 <<< 28))
            s = 128'sd1 <<< 28;
        if (s < -(128'sd1 <<< 28))
            s = -(128'sd1 <<< 28);
        g = ($signed({97'd0, gravity}) * s) >>> 28;
        ax = clamp32(128'(it.accel_x) - g);
        if (!calibrated) begin
            n = (calib_n == 0) ? 8'd1 : calib_n;
            bias_acc = bias_acc + 64'(ax);
            n_seen = n_seen + 1;
            if (n_seen >= n) begin
                bias = clamp32(128'(bias_acc) / $signed({120'd0, n}));
                calibrated = 1;
            end
            return;
        end
        clean = clamp32(ax - bias);
        if ((clean < 0 ? -clean : clean) < dead_zone)
            clean = 0;
        mag = ((clean < 0 ? -clean : clean) * dt) / 1000000;
        vel = clamp32(128'(vel) + (clean < 0 ? -$signed(mag) : $signed(mag)));
        bw = (blend_w > 17'd65536) ? 17'd65536 : blend_w;
        prod = 128'(vel) * (65536 - bw) + 128'(ref_speed) * bw;
        vel = clamp32(prod >>> 16);
        r.track_velocity = vel;
        r.yaw_rate_out = it.imu_yaw_rate;
        velocity_q.insert(velocity_q.size(), r);
    endtask

    assign pending = velocity_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            side_right = 0; half_track = 16384; gravity = 642908; dead_zone = 5243;
            still_thr = 655; blend_w = 1311; calib_n = 150;
            vel = 0; ref_speed = 0; bias = 0; last_stamp = 0;
            first_pending = 1; calibrated = 0; n_seen = 0; bias_acc = 0;
            velocity_q.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_SIDE_RIGHT: side_right = pwdata[0];
                    REG_HALF_TRACK: half_track = pwdata[30:0];
                    REG_GRAVITY:    gravity = pwdata[30:0];
                    REG_DEAD_ZONE:  dead_zone = pwdata[30:0];
                    REG_STILL:      still_thr = pwdata[30:0];
                    REG_BLEND:      blend_w = pwdata[16:0];
                    REG_CALIB:      calib_n = pwdata[7:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (velocity_q.size() == 0) begin
                    $display("%t: unexpected result %h", $realtime, out_data);
                    fail_count++;
                end else begin
                    want = velocity_q.pop_front();
                    if (want.track_velocity !== out_data.track_velocity) begin
                        $display("%t: track_velocity expected %0d actual %0d", $realtime,
                                 want.track_velocity, out_data.track_velocity);
                        fail_count++;
                    end
                    if (want.yaw_rate_out !== out_data.yaw_rate_out) begin
                        $display("%t: yaw_rate_out expected %0d actual %0d", $realtime,
                                 want.yaw_rate_out, out_data.yaw_rate_out);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                track_item(in_data);
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// Top of the track velocity estimator testbench: clock, reset, stimulus,
// register writes and verdict. Depends on imutv_pkg, the block and tb_imutv_checker.
module tb_top;
    import imutv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 300;
    localparam int STALL_CYCLES = 3000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    out_item_t   out_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          cycles = 0;
    logic        stall_req = 0;
    logic [31:0] stamp = 0;

    always #6 clk = ~clk;

    imu_track_velocity_estimator i_dut (
        .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
        .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    tb_imutv_checker i_checker (
        .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
        .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .pending
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: draw a random wait after each item, one long hold-off on request
    initial
    begin : receiver
        int   wait_cycles;
        logic stall_done;
        stall_done = 0;
        @(posedge clk);
        out_ready <= 1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                wait_cycles = $urandom_range(0, 4);
                if (stall_req && !stall_done)
                begin
                    stall_done = 1;
                    wait_cycles = STALL_CYCLES;
                end
                if (wait_cycles > 0)
                begin
                    out_ready <= 0;
                    repeat (wait_cycles) @(posedge clk);
                    out_ready <= 1;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // valid stays high into the next item when there is no gap
    task automatic send(input in_item_t it, input int gap);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // mostly near-unit quaternions, sometimes raw extremes
    function automatic in_item_t imu_item(input int step_us, input logic wild);
        in_item_t it;
        it = '0;
        it.op = OP_IMU;
        stamp = stamp + step_us;
        it.stamp_us = stamp;
        it.accel_x = wild ? $urandom() : $signed($urandom_range(0, 400000)) - 200000;
        it.quat_w = wild ? 16'($signed($urandom_range(0, 32768)) - 16384)
                         : 16'sd16384 - $signed(16'($urandom_range(0, 800)));
        it.quat_x = 16'($signed($urandom_range(0, wild ? 32768 : 2000)) - (wild ? 16384 : 1000));
        it.quat_y = 16'($signed($urandom_range(0, wild ? 32768 : 4000)) - (wild ? 16384 : 2000));
        it.quat_z = 16'($signed($urandom_range(0, wild ? 32768 : 2000)) - (wild ? 16384 : 1000));
        it.imu_yaw_rate = $urandom();
        it.odom_speed = $urandom();
        it.odom_turn_rate = $urandom();
        return it;
    endfunction

    function automatic in_item_t odom_item(input logic still, input logic wild);
        in_item_t it;
        it = '0;
        it.op = OP_ODOM;
        it.stamp_us = $urandom();
        it.accel_x = $urandom();
        it.imu_yaw_rate = $urandom();
        it.odom_speed = still ? $signed($urandom_range(0, 1200)) - 600
                      : wild ? $urandom() : $signed($urandom_range(0, 200000)) - 100000;
        it.odom_turn_rate = still ? $signed($urandom_range(0, 1200)) - 600
                          : wild ? $urandom() : $signed($urandom_range(0, 200000)) - 100000;
        return it;
    endfunction

    task automatic random_phase(input int count);
        in_item_t it;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: it = odom_item(1, 0);
                1: it = odom_item(0, 1);
                2, 3: it = odom_item(0, 0);
                4: it = imu_item($urandom(), 1);
                default: it = imu_item($urandom_range(1000, 20000), 0);
            endcase
            send(it, $urandom_range(0, 4));
        end
    endtask

    initial
    begin
        in_item_t it;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // directed: first stamp, short calibration, extremes, odometry cases
        write_reg(REG_CALIB, 0);
        send(imu_item(100, 0), 0);
        send(imu_item(5000, 0), 0);
        it = imu_item(10000, 0);
        it.accel_x = 32'sh7FFFFFFF; it.imu_yaw_rate = 32'sh80000000;
        send(it, 0);
        it = imu_item(10000, 0);
        it.accel_x = 32'sh80000000; it.imu_yaw_rate = 32'sh7FFFFFFF;
        send(it, 1);
        it = imu_item(0, 0);
        it.quat_w = 16384; it.quat_y = 16384; it.quat_x = -16384; it.quat_z = 16384;
        send(it, 0);
        it = imu_item(0, 0);
        it.quat_w = -16384; it.quat_y = 16384; it.quat_x = -16384; it.quat_z = -16384;
        it.stamp_us = stamp - 1;
        send(it, 0);
        stamp = it.stamp_us;
        it = imu_item(32'hFFFF_FFFF, 0);
        send(it, 0);
        it = odom_item(0, 0);
        it.odom_speed = 32'sh7FFFFFFF; it.odom_turn_rate = 32'sh80000000;
        send(it, 0);
        it.odom_speed = 32'sh80000000; it.odom_turn_rate = 32'sh7FFFFFFF;
        send(it, 2);
        send(odom_item(1, 0), 0);
        it = odom_item(0, 0);
        it.odom_speed = 0; it.odom_turn_rate = 0;
        send(it, 0);
        send(imu_item(8000, 0), 0);
        drain();

        // register sweep, including extremes
        write_reg(REG_SIDE_RIGHT, 1);
        write_reg(REG_HALF_TRACK, 32'h7FFF_FFFF);
        write_reg(REG_GRAVITY, 32'h7FFF_FFFF);
        write_reg(REG_DEAD_ZONE, 0);
        write_reg(REG_STILL, 32'h7FFF_FFFF);
        write_reg(REG_BLEND, 32'h1FFFF);
        write_reg(REG_CALIB, 255);
        random_phase(40);
        drain();

        write_reg(REG_SIDE_RIGHT, 0);
        write_reg(REG_HALF_TRACK, 16384);
        write_reg(REG_GRAVITY, 642908);
        write_reg(REG_DEAD_ZONE, 32'h7FFF_FFFF);
        write_reg(REG_STILL, 0);
        write_reg(REG_BLEND, 0);
        random_phase(60);
        drain();

        write_reg(REG_DEAD_ZONE, 5243);
        write_reg(REG_STILL, 655);
        write_reg(REG_BLEND, 65536);
        random_phase(60);
        // long receiver stall while items keep coming
        stall_req <= 1;
        random_phase(30);
        drain();

        write_reg(REG_BLEND, 1311);
        write_reg(REG_SIDE_RIGHT, 1);
        write_reg(REG_HALF_TRACK, $urandom());
        random_phase(280);
        drain();

        write_reg(REG_GRAVITY, $urandom());
        write_reg(REG_BLEND, $urandom_range(0, 65536));
        random_phase(270);
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
